/* sv/data_verification_hash_assert.svh */
// Assertion macros for the port-level assertion checker of the hash block.
`ifndef DATA_VERIFICATION_HASH_ASSERT_SVH
`define DATA_VERIFICATION_HASH_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define DVH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define DVH_ASSERT_RESET(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* sv/dvh_pkg.sv */
// Shared constants and types of the data verification hash block.
package dvh_pkg;

    localparam int unsigned ROUND_COUNT = 8;
    localparam int unsigned RND_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
    localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUND_COUNT - 1);

    localparam logic [31:0] MUL_P = 32'd32633;
    localparam logic [31:0] ADD_Q = 32'd65419;
    localparam logic [31:0] ADD_R = 32'd65469;
    localparam logic [31:0] ADD_S = 32'd32717;
    localparam logic [31:0] MUL_T = 32'd65497;
    localparam logic [31:0] MUL_V = 32'd131009;

    typedef logic [3:0][31:0] word_arr_t;

    typedef struct packed {
        logic      first_block;
        word_arr_t words;
    } blk_t;

    typedef struct packed {
        logic valid;
        blk_t blk;
    } qhead_t;

endpackage

/* sv/dvh_front.sv */
// Input side of the hash block: accepts blocks into a two-entry queue.
module dvh_front import dvh_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // word_a, word_b, word_c, word_d
    input  logic         s_tuser,   // first_block
    input  logic         pop,
    output qhead_t       head
);

    blk_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= '{first_block: s_tuser, words: s_tdata};
        end
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.blk   = mem_reg[rd_ptr_reg];

endmodule

/* sv/dvh_back.sv */
// Back end of the hash block: iterative mixing rounds, running sums and output register.
module dvh_back import dvh_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  qhead_t       head,
    output logic         pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // sum_a, sum_b, sum_c, sum_d
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PQRS = 5'b00010,
        ST_T    = 5'b00100,
        ST_V    = 5'b01000,
        ST_ACC  = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    word_arr_t        w_reg, w_next;
    logic             first_reg, first_next;
    logic [31:0]      p_reg, q_reg, r_reg, s_reg, t_reg;
    logic [31:0]      p_next, q_next, r_next, s_next, t_next;
    word_arr_t        sums_reg, sums_next;
    word_arr_t        out_reg, out_next;
    logic             m_valid_reg, m_valid_next;

    logic [31:0] p_mul, t_mul, qs_sum, v_mul, x_sum;
    logic        out_free;

    assign p_mul    = 32'(w_reg[0] * MUL_P);
    assign t_mul    = 32'((p_reg ^ r_reg) * MUL_T);
    assign qs_sum   = (q_reg ^ s_reg) + t_reg;
    assign v_mul    = 32'(qs_sum * MUL_V);
    assign x_sum    = t_reg + v_mul;
    assign out_free = !m_valid_reg || m_tready;
    assign pop      = (state_reg == ST_IDLE) && head.valid;

    always_comb begin
        state_next   = state_reg;
        rnd_next     = rnd_reg;
        w_next       = w_reg;
        first_next   = first_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        r_next       = r_reg;
        s_next       = s_reg;
        t_next       = t_reg;
        sums_next    = sums_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    w_next     = head.blk.words;
                    first_next = head.blk.first_block;
                    rnd_next   = '0;
                    state_next = ST_PQRS;
                end
            end
            ST_PQRS: begin
                p_next     = p_mul;
                q_next     = ADD_Q + w_reg[1];
                r_next     = ADD_R + w_reg[2];
                s_next     = ADD_S + w_reg[3];
                state_next = ST_T;
            end
            ST_T: begin
                t_next     = t_mul;
                state_next = ST_V;
            end
            ST_V: begin
                w_next[0] = p_reg ^ v_mul;
                w_next[1] = q_reg ^ x_sum;
                w_next[2] = r_reg ^ v_mul;
                w_next[3] = s_reg ^ x_sum;
                if (rnd_reg == RND_LAST) begin
                    state_next = ST_ACC;
                end else begin
                    rnd_next   = rnd_reg + 1'b1;
                    state_next = ST_PQRS;
                end
            end
            ST_ACC: begin
                if (out_free) begin
                    for (int i = 0; i < 4; i++) begin
                        sums_next[i] = (first_reg ? 32'd0 : sums_reg[i]) + w_reg[i];
                    end
                    out_next     = sums_next;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rnd_reg     <= '0;
            sums_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rnd_reg     <= rnd_next;
            sums_reg    <= sums_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg     <= w_next;
        first_reg <= first_next;
        p_reg     <= p_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        s_reg     <= s_next;
        t_reg     <= t_next;
        out_reg   <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

endmodule

/* sv/data_verification_hash.sv */
// Top level of the data verification hash block.
//
//   Channel  Direction  tdata (lowest bit up)              tuser
//   s_       in         word_a, word_b, word_c, word_d     first_block
//   m_       out        sum_a, sum_b, sum_c, sum_d         -
//
// Each block passes through the back end in order: it is loaded from the queue, runs
// ROUND_COUNT rounds of the PQRS, T and V states for the round's three dependent
// multiplications in the shared round unit, and is added into the running sums in ACC.
// Reset clears the queue, the running sums and the output valid flag.
// The two-entry queue takes transfers until full, while the back end is busy or stalled.
module data_verification_hash import dvh_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // word_a, word_b, word_c, word_d
    input  logic         s_tuser,   // first_block
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // sum_a, sum_b, sum_c, sum_d
);

    qhead_t head;
    logic   pop;

    dvh_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .pop      (pop),
        .head     (head)
    );

    dvh_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* sv/dvh_checker.sv */
// Port-level assertion checker for the data verification hash block, with its bind.
`include "data_verification_hash_assert.svh"

module dvh_checker import dvh_pkg::*; (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    `DVH_ASSERT(a_m_valid_holds, m_tvalid && !m_tready |=> m_tvalid, "Result withdrawn while stalled")
    `DVH_ASSERT(a_m_data_holds, m_tvalid && !m_tready |=> $stable(m_tdata), "Result changed while stalled")
    `DVH_ASSERT_RESET(a_reset_idle, !aresetn |=> !m_tvalid && s_tready, "Block not idle after reset")
    `DVH_ASSERT_RESET(a_no_early_result, !aresetn ##1 aresetn |-> !m_tvalid [*(3 * ROUND_COUNT + 2)], "Result before the first block could finish")

endmodule

bind data_verification_hash dvh_checker u_dvh_checker (.*);

/* tb/data_verification_hash_checker.sv */
// Checker for the data verification hash block: predicts the running sums and compares results.
module data_verification_hash_checker import dvh_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    output int unsigned  failures,
    output int unsigned  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    word_arr_t   sums_model;
    word_arr_t   expected_sums_q[$];
    int unsigned fail_total = 0;
    string       sum_names[4] = '{"sum_a", "sum_b", "sum_c", "sum_d"};

    function automatic word_arr_t mix_rounds(word_arr_t w);
        logic [31:0] p, q, r, s, t, v, x;
        for (int k = 0; k < ROUND_COUNT; k++) begin
            p = MUL_P * w[0];
            q = ADD_Q + w[1];
            r = ADD_R + w[2];
            s = ADD_S + w[3];
            t = MUL_T * (p ^ r);
            v = MUL_V * ((q ^ s) + t);
            x = t + v;
            w[0] = p ^ v;
            w[1] = q ^ x;
            w[2] = r ^ v;
            w[3] = s ^ x;
        end
        return w;
    endfunction

    always @(posedge aclk) begin
        word_arr_t got;
        word_arr_t want;
        word_arr_t mixed;
        if (!aresetn) begin
            sums_model = '0;
            expected_sums_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_sums_q.size() == 0) begin
                    $error("unexpected result transfer: %h", m_tdata);
                    fail_total++;
                end else begin
                    want = expected_sums_q.pop_front();
                    for (int i = 0; i < 4; i++) begin
                        if (got[i] !== want[i]) begin
                            $error("%s: expected %h, actual %h", sum_names[i], want[i], got[i]);
                            fail_total++;
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser) begin
                    sums_model = '0;
                end
                mixed = mix_rounds(word_arr_t'(s_tdata));
                for (int i = 0; i < 4; i++) begin
                    sums_model[i] = sums_model[i] + mixed[i];
                end
                expected_sums_q.push_back(sums_model);
            end
        end
        pending  <= expected_sums_q.size();
        failures <= fail_total;
    end

endmodule

/* tb/data_verification_hash_tb.sv */
// Top of the data verification hash testbench: clock, reset, stimulus and verdict.
module data_verification_hash_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT       = 35;
    localparam int RANDOM_BLOCKS  = 1800;
    localparam int STALL_LIMIT    = 5000;
    localparam int TAIL_CYCLES    = 80;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    int unsigned  failures;
    int unsigned  pending;
    bit           steady;
    int unsigned  quiet_cycles;

    data_verification_hash uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    data_verification_hash_checker checker_i (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .failures (failures),
        .pending  (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_block(input logic first, input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input logic [31:0] d);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom, $urandom, $urandom};
            s_tuser  <= 1'($urandom_range(1));
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {d, c, b, a};
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= 1'b0;
        steady       = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_block(1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_block(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_block(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_block(1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_block(1'b0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        send_block(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        send_block(1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_block(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_block(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_block(1'b0, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        send_block(1'b1, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_block(1'b1, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_block(1'b0, 32'h0001_0000, 32'h0000_FFFF, 32'hFFFF_0000, 32'h7FFF_FFFF);

        drain_results();

        for (int n = 0; n < RANDOM_BLOCKS; n++) begin
            steady = (n >= 700) && (n < 1000);
            send_block($urandom_range(15) == 0, rand_word(), rand_word(), rand_word(),
                       rand_word());
            if (n % 400 == 399) begin
                drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (failures == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
